// ===== rtl/sldf_pkg.sv =====
// Shared constants and types of the sync/length/checksum deframer.
`default_nettype none

package sldf_pkg;

	localparam logic [7:0]  SYNC_FIRST       = 8'h55;
	localparam logic [7:0]  SYNC_SECOND      = 8'hAA;
	localparam logic [7:0]  CMD_DATAPOINT    = 8'h07;
	localparam logic [15:0] MAX_LENGTH_RESET = 16'd512;

	typedef enum logic [1:0] {
		KIND_HEADER  = 2'd0,
		KIND_PAYLOAD = 2'd1,
		KIND_END     = 2'd2
	} kind_t;

	typedef struct packed {
		kind_t       kind;
		logic [7:0]  version;
		logic [7:0]  command;
		logic [15:0] length;
		logic [7:0]  data;
		logic [15:0] index;
		logic        sum_match;
		logic        last;
		logic        datapoint;
	} result_t;

endpackage

`default_nettype wire

// ===== rtl/sldf_if.sv =====
// Handshake interfaces: received byte, configuration write and result channels.
`default_nettype none

interface sldf_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

interface sldf_cfg_if;
	logic        valid;
	logic        ready;
	logic [15:0] max_length;

	modport source (output valid, output max_length, input ready);
	modport sink (input valid, input max_length, output ready);
endinterface

interface sldf_result_if;
	logic        valid;
	logic        ready;
	logic [1:0]  result_kind;
	logic [7:0]  frame_version;
	logic [7:0]  frame_command;
	logic [15:0] frame_length;
	logic [7:0]  data_byte;
	logic [15:0] byte_index;
	logic        sum_match;
	logic        frame_last;
	logic        datapoint_report;

	modport source (
		output valid, output result_kind, output frame_version, output frame_command,
		output frame_length, output data_byte, output byte_index, output sum_match,
		output frame_last, output datapoint_report, input ready
	);
	modport sink (
		input valid, input result_kind, input frame_version, input frame_command,
		input frame_length, input data_byte, input byte_index, input sum_match,
		input frame_last, input datapoint_report, output ready
	);
endinterface

`default_nettype wire

// ===== rtl/sldf_parser.sv =====
// Input byte register, max_length register and frame parse state machine.
`default_nettype none

module sldf_parser (
	input  wire logic           clk,
	input  wire logic           arst_n,
	sldf_byte_if.sink           rx,
	sldf_cfg_if.sink            cfg,
	input  wire logic           can_out,
	output sldf_pkg::result_t   res,
	output logic                res_fire
);

	typedef enum logic [2:0] {
		PH_SYNC1   = 3'd0,
		PH_SYNC2   = 3'd1,
		PH_VER     = 3'd2,
		PH_CMD     = 3'd3,
		PH_LENHI   = 3'd4,
		PH_LENLO   = 3'd5,
		PH_PAYLOAD = 3'd6,
		PH_CKSUM   = 3'd7
	} phase_t;

	logic [7:0]  byte_s1;
	logic        valid_s1;
	logic [15:0] max_length_q;

	phase_t      phase_q, phase_d;
	logic [7:0]  ver_q, ver_d;
	logic [7:0]  cmd_q, cmd_d;
	logic [7:0]  len_hi_q, len_hi_d;
	logic [15:0] len_q, len_d;
	logic [15:0] count_q, count_d;
	logic [7:0]  sum_q, sum_d;
	logic [15:0] new_len;
	logic [15:0] count_inc;
	logic        emit;
	logic        proc;

	assign proc      = valid_s1 && can_out;
	assign rx.ready  = !valid_s1 || can_out;
	assign cfg.ready = 1'b1;
	assign new_len   = {len_hi_q, byte_s1};
	assign count_inc = count_q + 16'd1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1     <= 1'b0;
			max_length_q <= sldf_pkg::MAX_LENGTH_RESET;
		end else begin
			if (rx.valid && rx.ready) begin
				valid_s1 <= 1'b1;
			end else if (proc) begin
				valid_s1 <= 1'b0;
			end
			if (cfg.valid) begin
				max_length_q <= cfg.max_length;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rx.valid && rx.ready) begin
			byte_s1 <= rx.rx_byte;
		end
	end

	always_comb begin
		phase_d  = phase_q;
		ver_d    = ver_q;
		cmd_d    = cmd_q;
		len_hi_d = len_hi_q;
		len_d    = len_q;
		count_d  = count_q;
		sum_d    = sum_q;
		emit     = 1'b0;
		res.kind      = sldf_pkg::KIND_HEADER;
		res.data      = 8'd0;
		res.index     = 16'd0;
		res.sum_match = 1'b0;
		res.last      = 1'b0;
		case (phase_q)
			PH_SYNC1: begin
				if (byte_s1 == sldf_pkg::SYNC_FIRST) begin
					sum_d   = byte_s1;
					phase_d = PH_SYNC2;
				end
			end
			PH_SYNC2: begin
				if (byte_s1 == sldf_pkg::SYNC_SECOND) begin
					sum_d   = sum_q + byte_s1;
					phase_d = PH_VER;
				end else if (byte_s1 != sldf_pkg::SYNC_FIRST) begin
					phase_d = PH_SYNC1;
				end
			end
			PH_VER: begin
				ver_d   = byte_s1;
				sum_d   = sum_q + byte_s1;
				phase_d = PH_CMD;
			end
			PH_CMD: begin
				cmd_d   = byte_s1;
				sum_d   = sum_q + byte_s1;
				phase_d = PH_LENHI;
			end
			PH_LENHI: begin
				len_hi_d = byte_s1;
				sum_d    = sum_q + byte_s1;
				phase_d  = PH_LENLO;
			end
			PH_LENLO: begin
				sum_d   = sum_q + byte_s1;
				len_d   = new_len;
				count_d = 16'd0;
				if (new_len == 16'd0) begin
					phase_d = PH_CKSUM;
					emit    = 1'b1;
				end else if (new_len > max_length_q) begin
					phase_d = PH_SYNC1;
				end else begin
					phase_d = PH_PAYLOAD;
					emit    = 1'b1;
				end
			end
			PH_PAYLOAD: begin
				sum_d     = sum_q + byte_s1;
				emit      = 1'b1;
				res.kind  = sldf_pkg::KIND_PAYLOAD;
				res.data  = byte_s1;
				res.index = count_q;
				count_d   = count_inc;
				if (count_inc >= len_q) begin
					phase_d = PH_CKSUM;
				end
			end
			PH_CKSUM: begin
				emit          = 1'b1;
				res.kind      = sldf_pkg::KIND_END;
				res.sum_match = (sum_q == byte_s1);
				res.last      = 1'b1;
				phase_d       = PH_SYNC1;
			end
			default: begin
				phase_d = PH_SYNC1;
			end
		endcase
		res.version   = ver_d;
		res.command   = cmd_d;
		res.length    = len_d;
		res.datapoint = (cmd_d == sldf_pkg::CMD_DATAPOINT);
	end

	assign res_fire = proc && emit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_SYNC1;
			ver_q    <= 8'd0;
			cmd_q    <= 8'd0;
			len_hi_q <= 8'd0;
			len_q    <= 16'd0;
			count_q  <= 16'd0;
			sum_q    <= 8'd0;
		end else if (proc) begin
			phase_q  <= phase_d;
			ver_q    <= ver_d;
			cmd_q    <= cmd_d;
			len_hi_q <= len_hi_d;
			len_q    <= len_d;
			count_q  <= count_d;
			sum_q    <= sum_d;
		end
	end

`ifndef SYNTHESIS
	a_payload_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_fire && res.kind == sldf_pkg::KIND_PAYLOAD |-> res.index < res.length)
		else $error("payload index beyond declared length");

	a_no_result_in_header: assert property (@(posedge clk) disable iff (!arst_n)
		proc && (phase_q == PH_SYNC1 || phase_q == PH_SYNC2 || phase_q == PH_VER ||
		phase_q == PH_CMD || phase_q == PH_LENHI) |-> !res_fire)
		else $error("result given before length taken");

	a_repeat_sync: assert property (@(posedge clk) disable iff (!arst_n)
		proc && phase_q == PH_SYNC2 && byte_s1 == sldf_pkg::SYNC_FIRST
		|=> phase_q == PH_SYNC2 && sum_q == sldf_pkg::SYNC_FIRST)
		else $error("repeated sync byte lost the hunt");

	a_end_closes: assert property (@(posedge clk) disable iff (!arst_n)
		proc && phase_q == PH_CKSUM |=> phase_q == PH_SYNC1)
		else $error("frame end did not return to hunt");
`endif

endmodule

`default_nettype wire

// ===== rtl/sldf_out_reg.sv =====
// Result register driving the result channel.
`default_nettype none

module sldf_out_reg (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              load,
	input  wire sldf_pkg::result_t d,
	output logic                   can_load,
	sldf_result_if.source          result
);

	sldf_pkg::result_t res_q;
	logic              valid_q;

	assign can_load = !valid_q || result.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (can_load) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (can_load && load) begin
			res_q <= d;
		end
	end

	assign result.valid            = valid_q;
	assign result.result_kind      = res_q.kind;
	assign result.frame_version    = res_q.version;
	assign result.frame_command    = res_q.command;
	assign result.frame_length     = res_q.length;
	assign result.data_byte        = res_q.data;
	assign result.byte_index       = res_q.index;
	assign result.sum_match        = res_q.sum_match;
	assign result.frame_last       = res_q.last;
	assign result.datapoint_report = res_q.datapoint;

endmodule

`default_nettype wire

// ===== rtl/sync_length_checksum_deframer_top.sv =====
// Top level of the sync/length/checksum deframer.
// Takes one received byte per cycle. Each byte passes an input register, then
// the parse logic writes at most one result into the result register, which
// offers it. A new byte is taken every cycle unless the input register holds a
// byte, the result register is full and its sink is not ready.
// Payload bytes are tentative: drop the frame when the frame-end item has
// sum_match low. max_length may be written only while the block is idle.
`default_nettype none

module sync_length_checksum_deframer_top (
	input  wire logic     clk,
	input  wire logic     arst_n,
	sldf_byte_if.sink     rx,
	sldf_cfg_if.sink      cfg,
	sldf_result_if.source result
);

	sldf_pkg::result_t res;
	logic              res_fire;
	logic              can_out;

	sldf_parser u_parser (
		.clk      (clk),
		.arst_n   (arst_n),
		.rx       (rx),
		.cfg      (cfg),
		.can_out  (can_out),
		.res      (res),
		.res_fire (res_fire)
	);

	sldf_out_reg u_out_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (res_fire),
		.d        (res),
		.can_load (can_out),
		.result   (result)
	);

endmodule

`default_nettype wire
